### rtl/assert_macros.svh
// Concurrent assertion helpers, synchronous active-high reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tnsp_pkg.sv
`default_nettype none
package tnsp_pkg;
  localparam int CRD_W  = 32;  // vertex coordinate, Q16.16
  localparam int REF_W  = 18;  // r, s, Q1.16
  localparam int WGT_W  = 20;  // doubled weights
  localparam int PROD_W = 52;  // weight * coordinate
  localparam int SUM_W  = 53;  // 2p component
  localparam int SHF_W  = 6;   // bit index within SUM_W
  localparam int NRM_W  = 30;  // normalized magnitude
  localparam int SQ_W   = 60;
  localparam int SSQ_W  = 62;
  localparam int ROOT_W = 31;
  localparam int QUO_W  = 32;

  localparam logic signed [WGT_W-1:0] WGT_ONE = 20'sd65536;
  localparam logic [SHF_W-1:0]        NRM_TOP = 6'd29;
  localparam logic [QUO_W-1:0]        Q30_ONE = 32'h4000_0000;

  typedef struct packed {
    logic en;     // pipeline advances this cycle
    logic valid;  // item present at the stage input
  } pipe_ctl_t;
endpackage
`default_nettype wire

### rtl/tnsp_affine.sv
`default_nettype none
module tnsp_affine (
  input  logic                                      clk,
  input  logic                                      rst,
  input  tnsp_pkg::pipe_ctl_t                       ctl,
  input  logic [8:0][tnsp_pkg::CRD_W-1:0]           vtx,
  input  logic signed [tnsp_pkg::REF_W-1:0]         ref_r,
  input  logic signed [tnsp_pkg::REF_W-1:0]         ref_s,
  output logic                                      valid,
  output logic [2:0][tnsp_pkg::SUM_W-1:0]           pnt
);
  import tnsp_pkg::*;

  logic signed [WGT_W-1:0]  wgt [3];
  logic signed [PROD_W-1:0] prod [9];
  logic                     prod_valid;

  always_comb begin
    wgt[0] = -(WGT_W'(ref_r) + WGT_W'(ref_s));
    wgt[1] = WGT_ONE + WGT_W'(ref_r);
    wgt[2] = WGT_ONE + WGT_W'(ref_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid      <= 1'b0;
    end else if (ctl.en) begin
      prod_valid <= ctl.valid;
      valid      <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < 9; k++) begin
        prod[k] <= PROD_W'(wgt[k/3]) * PROD_W'($signed(vtx[k]));
      end
      for (int i = 0; i < 3; i++) begin
        pnt[i] <= SUM_W'(prod[i]) + SUM_W'(prod[3+i]) + SUM_W'(prod[6+i]);
      end
    end
  end
endmodule
`default_nettype wire

### rtl/tnsp_norm.sv
`default_nettype none
module tnsp_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  tnsp_pkg::pipe_ctl_t                 ctl,
  input  logic [2:0][tnsp_pkg::SUM_W-1:0]     pnt,
  output logic                                valid,
  output logic [2:0][tnsp_pkg::NRM_W-1:0]     nrm,
  output logic [2:0]                          sgn,
  output logic                                zero,
  output logic [tnsp_pkg::SSQ_W-1:0]          ssq
);
  import tnsp_pkg::*;

  // stage 1: sign / magnitude
  logic                  v1;
  logic [2:0][SUM_W-1:0] mag1;
  logic [2:0]            sgn1;
  // stage 2: leading one of the largest
  logic                  v2;
  logic [2:0][SUM_W-1:0] mag2;
  logic [2:0]            sgn2;
  logic [SHF_W-1:0]      msb2;
  logic                  zero2;
  // stage 3: common shift
  logic                  v3;
  logic [2:0][NRM_W-1:0] nrm3;
  logic [2:0]            sgn3;
  logic                  zero3;
  // stage 4: squares
  logic                  v4;
  logic [2:0][NRM_W-1:0] nrm4;
  logic [2:0][SQ_W-1:0]  sq4;
  logic [2:0]            sgn4;
  logic                  zero4;

  logic [SUM_W-1:0]      big;
  logic [SHF_W-1:0]      msb;
  logic [2:0][SUM_W-1:0] shf;

  always_comb begin
    big = mag1[0] | mag1[1] | mag1[2];
    msb = '0;
    for (int b = 0; b < SUM_W; b++) begin
      if (big[b]) msb = SHF_W'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb2 >= NRM_TOP) shf[i] = mag2[i] >> (msb2 - NRM_TOP);
      else                 shf[i] = mag2[i] << (NRM_TOP - msb2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; valid <= 1'b0;
    end else if (ctl.en) begin
      v1 <= ctl.valid; v2 <= v1; v3 <= v2; v4 <= v3; valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        sgn1[i] <= pnt[i][SUM_W-1];
        mag1[i] <= pnt[i][SUM_W-1] ? SUM_W'(-pnt[i]) : pnt[i];
      end
      mag2  <= mag1;
      sgn2  <= sgn1;
      msb2  <= msb;
      zero2 <= (big == '0);
      for (int i = 0; i < 3; i++) nrm3[i] <= shf[i][NRM_W-1:0];
      sgn3  <= sgn2;
      zero3 <= zero2;
      for (int i = 0; i < 3; i++) sq4[i] <= SQ_W'(nrm3[i]) * SQ_W'(nrm3[i]);
      nrm4  <= nrm3;
      sgn4  <= sgn3;
      zero4 <= zero3;
      ssq   <= SSQ_W'(sq4[0]) + SSQ_W'(sq4[1]) + SSQ_W'(sq4[2]);
      nrm   <= nrm4;
      sgn   <= sgn4;
      zero  <= zero4;
    end
  end
endmodule
`default_nettype wire

### rtl/tnsp_isqrt.sv
`default_nettype none
module tnsp_isqrt #(
  parameter int SB_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tnsp_pkg::pipe_ctl_t          ctl,
  input  logic [tnsp_pkg::SSQ_W-1:0]   rad,
  input  logic [SB_W-1:0]              side,
  output logic                         valid,
  output logic [tnsp_pkg::ROOT_W-1:0]  root,
  output logic [SB_W-1:0]              side_out
);
  import tnsp_pkg::*;

  localparam int TRL_W = SSQ_W + 1;

  // one root bit per stage, msb first
  logic [SSQ_W-1:0]  rem_q [ROOT_W];
  logic [ROOT_W-1:0] rt_q  [ROOT_W];
  logic [SB_W-1:0]   sb_q  [ROOT_W];
  logic              vld_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stg
    localparam int K = ROOT_W - 1 - s;
    logic [SSQ_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_rt;
    logic [SB_W-1:0]   cur_sb;
    logic              cur_vld;
    logic [TRL_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign cur_rem = rad;
      assign cur_rt  = '0;
      assign cur_sb  = side;
      assign cur_vld = ctl.valid;
    end else begin : g_next
      assign cur_rem = rem_q[s-1];
      assign cur_rt  = rt_q[s-1];
      assign cur_sb  = sb_q[s-1];
      assign cur_vld = vld_q[s-1];
    end

    assign trial = (TRL_W'(cur_rt) << (K + 1)) | (TRL_W'(1) << (2 * K));
    assign ge    = TRL_W'(cur_rem) >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld_q[s] <= 1'b0;
      else if (ctl.en) vld_q[s] <= cur_vld;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_q[s] <= ge ? cur_rem - trial[SSQ_W-1:0] : cur_rem;
        rt_q[s]  <= ge ? cur_rt | (ROOT_W'(1) << K) : cur_rt;
        sb_q[s]  <= cur_sb;
      end
    end
  end

  assign valid    = vld_q[ROOT_W-1];
  assign root     = rt_q[ROOT_W-1];
  assign side_out = sb_q[ROOT_W-1];
endmodule
`default_nettype wire

### rtl/tnsp_div.sv
`default_nettype none
module tnsp_div #(
  parameter int SB_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tnsp_pkg::pipe_ctl_t               ctl,
  input  logic [2:0][tnsp_pkg::NRM_W-1:0]   nrm,
  input  logic [tnsp_pkg::ROOT_W-1:0]       den,
  input  logic [SB_W-1:0]                   side,
  output logic                              valid,
  output logic [2:0][tnsp_pkg::QUO_W-1:0]   quo,
  output logic [SB_W-1:0]                   side_out
);
  import tnsp_pkg::*;

  // numerator = nrm*2^30 + den/2; its top bits (nrm >> 2) seed the remainder,
  // the low QUO_W bits are brought down one per stage.
  localparam int HI_W = NRM_W - 2;

  logic [2:0][QUO_W-1:0] rem_q [QUO_W];
  logic [2:0][QUO_W-1:0] lo_q  [QUO_W];
  logic [2:0][QUO_W-1:0] quo_q [QUO_W];
  logic [ROOT_W-1:0]     den_q [QUO_W];
  logic [SB_W-1:0]       sb_q  [QUO_W];
  logic                  vld_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stg
    logic [2:0][QUO_W-1:0] cur_rem, cur_lo, cur_quo;
    logic [ROOT_W-1:0]     cur_den;
    logic [SB_W-1:0]       cur_sb;
    logic                  cur_vld;
    logic [2:0][QUO_W-1:0] cand;
    logic [2:0]            ge;

    if (s == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign cur_rem[i] = QUO_W'(nrm[i][NRM_W-1 -: HI_W]);
        assign cur_lo[i]  = {nrm[i][1:0], den[ROOT_W-1:1]};
      end
      assign cur_quo = '0;
      assign cur_den = den;
      assign cur_sb  = side;
      assign cur_vld = ctl.valid;
    end else begin : g_next
      assign cur_rem = rem_q[s-1];
      assign cur_lo  = lo_q[s-1];
      assign cur_quo = quo_q[s-1];
      assign cur_den = den_q[s-1];
      assign cur_sb  = sb_q[s-1];
      assign cur_vld = vld_q[s-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = {cur_rem[i][QUO_W-2:0], cur_lo[i][QUO_W-1-s]};
        ge[i]   = cand[i] >= QUO_W'(cur_den);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld_q[s] <= 1'b0;
      else if (ctl.en) vld_q[s] <= cur_vld;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[s][i] <= ge[i] ? cand[i] - QUO_W'(cur_den) : cand[i];
          quo_q[s][i] <= {cur_quo[i][QUO_W-2:0], ge[i]};
        end
        lo_q[s]  <= cur_lo;
        den_q[s] <= cur_den;
        sb_q[s]  <= cur_sb;
      end
    end
  end

  assign valid    = vld_q[QUO_W-1];
  assign quo      = quo_q[QUO_W-1];
  assign side_out = sb_q[QUO_W-1];
endmodule
`default_nettype wire

### rtl/triangle_node_sphere_projection_unit.sv
// Channel | Dir | tdata                                  | tuser
// s_*     | in  | v1_x v1_y v1_z v2_x .. v3_z, ref_r ref_s | -
// m_*     | out | sphere_x sphere_y sphere_z              | degenerate
//
// Fully pipelined: one node per cycle unless the output stalls; register stages are
// 2 affine, 5 normalize/square, 31 square-root bits, 32 quotient bits and 1 out.
// Depth is set by the bit-per-stage square root and divider.
// rst clears only the valid bits; payload registers carry no reset.
// A stalled result freezes the whole pipe in place; s_tready = !m_tvalid | m_tready.
`default_nettype none
`include "assert_macros.svh"
module triangle_node_sphere_projection_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [327:0] s_tdata,   // v1_x,v1_y,v1_z,v2_x,v2_y,v2_z,v3_x,v3_y,v3_z,ref_r,ref_s,pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // sphere_x, sphere_y, sphere_z
  output logic         m_tuser    // degenerate
);
  import tnsp_pkg::*;

  localparam int ISB_W = 3 * NRM_W + 4;  // nrm, sgn, zero
  localparam int DSB_W = 4;              // sgn, zero
  localparam logic signed [QUO_W-1:0] ONE_S = 32'sd1073741824;

  logic                  adv;
  pipe_ctl_t             ctl_in, ctl_nrm, ctl_sq, ctl_dv;
  logic [8:0][CRD_W-1:0] vtx;
  logic signed [REF_W-1:0] ref_r, ref_s;

  logic                  aff_valid;
  logic [2:0][SUM_W-1:0] pnt;

  logic                  nrm_valid;
  logic [2:0][NRM_W-1:0] nrm;
  logic [2:0]            sgn;
  logic                  zero;
  logic [SSQ_W-1:0]      ssq;

  logic                  sq_valid;
  logic [ROOT_W-1:0]     root;
  logic [ISB_W-1:0]      sq_side;
  logic [2:0][NRM_W-1:0] sq_nrm;

  logic                  dv_valid;
  logic [2:0][QUO_W-1:0] quo;
  logic [DSB_W-1:0]      dv_side;
  logic [2:0][QUO_W-1:0] res;
  logic [QUO_W-1:0]      cap;
  logic signed [QUO_W-1:0] out_x;

  // whole pipe moves unless a result sits unaccepted
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign ctl_in   = '{en: adv, valid: s_tvalid};
  assign ctl_nrm  = '{en: adv, valid: aff_valid};
  assign ctl_sq   = '{en: adv, valid: nrm_valid};
  assign ctl_dv   = '{en: adv, valid: sq_valid};

  always_comb begin
    for (int k = 0; k < 9; k++) vtx[k] = s_tdata[k*CRD_W +: CRD_W];
  end
  assign ref_r = s_tdata[9*CRD_W +: REF_W];
  assign ref_s = s_tdata[9*CRD_W+REF_W +: REF_W];

  tnsp_affine u_affine (
    .clk, .rst, .ctl(ctl_in), .vtx, .ref_r, .ref_s,
    .valid(aff_valid), .pnt
  );

  tnsp_norm u_norm (
    .clk, .rst, .ctl(ctl_nrm), .pnt,
    .valid(nrm_valid), .nrm, .sgn, .zero, .ssq
  );

  tnsp_isqrt #(.SB_W(ISB_W)) u_isqrt (
    .clk, .rst, .ctl(ctl_sq), .rad(ssq),
    .side({nrm, sgn, zero}),
    .valid(sq_valid), .root, .side_out(sq_side)
  );

  assign sq_nrm = sq_side[ISB_W-1 -: 3*NRM_W];

  tnsp_div #(.SB_W(DSB_W)) u_div (
    .clk, .rst, .ctl(ctl_dv), .nrm(sq_nrm), .den(root),
    .side(sq_side[DSB_W-1:0]),
    .valid(dv_valid), .quo, .side_out(dv_side)
  );

  // round-half-up quotient is capped at 1.0, then signed; zero point gives zeros
  always_comb begin
    cap = '0;
    for (int i = 0; i < 3; i++) begin
      cap    = (quo[i] > Q30_ONE) ? Q30_ONE : quo[i];
      res[i] = dv_side[0] ? '0 : (dv_side[1+i] ? QUO_W'(-cap) : cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= res;
      m_tuser <= dv_side[0];
    end
  end

  assign out_x = m_tdata[31:0];

  `ASSERT_IMPL(a_degen_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `ASSERT_IMPL(a_nondegen_nonzero, clk, rst, m_tvalid && !m_tuser, m_tdata != '0)
  `ASSERT_IMPL(a_x_range, clk, rst, m_tvalid, (out_x <= ONE_S) && (out_x >= -ONE_S))
  `ASSERT_NEXT(a_idle_stays_empty, clk, rst, !m_tvalid && !dv_valid, !m_tvalid)
endmodule
`default_nettype wire

### verif/triangle_node_sphere_projection_unit_tb.sv
`timescale 1ns / 100ps
module triangle_node_sphere_projection_unit_tb;
  import tnsp_pkg::*;

  typedef struct packed {
    logic [REF_W-1:0] rs;
    logic [REF_W-1:0] rr;
    logic [CRD_W-1:0] v3z, v3y, v3x, v2z, v2y, v2x, v1z, v1y, v1x;
  } node_t;

  typedef struct packed {
    logic             degen;
    logic [CRD_W-1:0] sz, sy, sx;
  } unit_vec_t;

  localparam int LIMIT_CYCLES = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [327:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         m_tuser;

  node_t     pending_nodes[$];
  unit_vec_t expected_vecs[$];
  int        mismatches = 0;
  int        nodes_sent = 0;
  int        vecs_seen = 0;
  int        degen_seen = 0;
  int        cycle = 0;
  bit        stim_done = 1'b0;
  bit        calm = 1'b0;  // stretch with no idling on either side

  triangle_node_sphere_projection_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Affine map of the node onto the triangle, then projection to unit length.
  function automatic unit_vec_t project_node(node_t n);
    unit_vec_t      u;
    longint         r, s, a1, a2, a3;
    longint         p[3];
    longint unsigned m[3];
    longint unsigned big, len, q;
    logic [CRD_W-1:0] c1[3], c2[3], c3[3];
    r = longint'($signed(n.rr));
    s = longint'($signed(n.rs));
    a1 = -(r + s);
    a2 = 65536 + r;
    a3 = 65536 + s;
    c1 = '{n.v1x, n.v1y, n.v1z};
    c2 = '{n.v2x, n.v2y, n.v2z};
    c3 = '{n.v3x, n.v3y, n.v3z};
    for (int i = 0; i < 3; i++) begin
      p[i] = a1 * longint'($signed(c1[i])) + a2 * longint'($signed(c2[i]))
           + a3 * longint'($signed(c3[i]));
      m[i] = p[i] < 0 ? -p[i] : p[i];
    end
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    u = '0;
    if (big == 0) begin
      u.degen = 1'b1;
      return u;
    end
    while (big < (64'd1 << 29)) begin
      big <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (big >= (64'd1 << 30)) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      if (q > 64'(Q30_ONE)) q = 64'(Q30_ONE);
      if (p[i] < 0) q = -q;
      case (i)
        0: u.sx = q[31:0];
        1: u.sy = q[31:0];
        default: u.sz = q[31:0];
      endcase
    end
    return u;
  endfunction

  function automatic logic [CRD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return CRD_W'($signed($urandom_range(0, 2000)) - 1000) << 16;
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))} ^
                ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
      default: return CRD_W'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [REF_W-1:0] rand_ref();
    case ($urandom_range(0, 9))
      0: return REF_W'($urandom);  // any pattern, extrapolates
      1: return REF_W'(65536);
      2: return REF_W'(-65536);
      default: return REF_W'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  function automatic node_t rand_node();
    node_t n;
    n.v1x = rand_coord(); n.v1y = rand_coord(); n.v1z = rand_coord();
    n.v2x = rand_coord(); n.v2y = rand_coord(); n.v2z = rand_coord();
    n.v3x = rand_coord(); n.v3y = rand_coord(); n.v3z = rand_coord();
    n.rr = rand_ref(); n.rs = rand_ref();
    // occasionally shared vertices so the point can collapse to zero
    if ($urandom_range(0, 19) == 0) begin
      n.v2x = n.v1x; n.v2y = n.v1y; n.v2z = n.v1z;
      n.v3x = 0; n.v3y = 0; n.v3z = 0;
      n.rs = REF_W'(65536);
    end
    return n;
  endfunction

  function automatic node_t fill_node(logic [CRD_W-1:0] c, logic [REF_W-1:0] r,
                                      logic [REF_W-1:0] s);
    node_t n;
    n.v1x = c; n.v1y = c; n.v1z = c;
    n.v2x = c; n.v2y = c; n.v2z = c;
    n.v3x = c; n.v3y = c; n.v3z = c;
    n.rr = r; n.rs = s;
    return n;
  endfunction

  initial begin
    node_t n;
    // directed: extremes, zero point, reference corners, out-of-range r/s
    pending_nodes.push_back(fill_node(32'h0, '0, '0));
    pending_nodes.push_back(fill_node(32'h7FFF_FFFF, '0, '0));
    pending_nodes.push_back(fill_node(32'h8000_0000, '0, '0));
    pending_nodes.push_back(fill_node(32'h8000_0000, 18'h1FFFF, 18'h1FFFF));
    pending_nodes.push_back(fill_node(32'h7FFF_FFFF, 18'h20000, 18'h20000));
    pending_nodes.push_back(fill_node(32'h8000_0000, 18'h20000, 18'h1FFFF));
    pending_nodes.push_back(fill_node(32'hFFFF_FFFF, 18'h3FFFF, 18'h3FFFF));
    pending_nodes.push_back(fill_node(32'h1, 18'h10000, 18'h30000));
    n = fill_node(32'h0, REF_W'(-65536), REF_W'(-65536));
    n.v1x = 32'h0001_0000;  // vertex 1 corner
    pending_nodes.push_back(n);
    n = fill_node(32'h0, REF_W'(65536), REF_W'(-65536));
    n.v2y = 32'hFFFF_0000;  // vertex 2 corner
    pending_nodes.push_back(n);
    n = fill_node(32'h0, REF_W'(-65536), REF_W'(65536));
    n.v3z = 32'h7FFF_FFFF;  // vertex 3 corner
    pending_nodes.push_back(n);
    n = fill_node(32'h0, REF_W'(-65536), REF_W'(65536));
    n.v3x = 32'h1; n.v3y = 32'h8000_0000;
    pending_nodes.push_back(n);
    n = fill_node(32'h0, '0, '0);
    n.v1x = 32'h3; n.v2y = 32'hFFFF_FFFD; n.v3z = 32'h5;
    pending_nodes.push_back(n);
    n = fill_node(32'h0001_0000, 18'h2AAAA, 18'h15555);
    n.v2x = 32'hAAAA_AAAA; n.v3y = 32'h5555_5555;
    pending_nodes.push_back(n);
    for (int i = 0; i < 1140; i++) pending_nodes.push_back(rand_node());

    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: source side of the stream.
  always @(posedge clk) begin
    if (!rst) begin
      calm <= (cycle > 300 && cycle < 800);
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) nodes_sent <= nodes_sent + 1;
        if (pending_nodes.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          node_t n;
          n = pending_nodes.pop_front();
          expected_vecs.push_back(project_node(n));
          s_tdata <= {4'h0, n};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          if (pending_nodes.size() == 0) stim_done <= 1'b1;
        end
      end
      m_tready <= calm || $urandom_range(0, 99) >= 23;
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && m_tvalid && m_tready) begin
      unit_vec_t got, want;
      got = {m_tuser, m_tdata};
      vecs_seen <= vecs_seen + 1;
      if (m_tuser) degen_seen <= degen_seen + 1;
      if (expected_vecs.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer %h", got);
      end else begin
        want = expected_vecs.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch #%0d: x %h/%h y %h/%h z %h/%h degen %b/%b (exp/act)",
                     vecs_seen, want.sx, got.sx, want.sy, got.sy, want.sz, got.sz,
                     want.degen, got.degen);
        end
      end
    end
  end

  initial begin
    wait (stim_done && !s_tvalid && expected_vecs.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d nodes driven, %0d vectors checked (%0d degenerate)",
             nodes_sent, vecs_seen, degen_seen);
    if (mismatches == 0) $display("triangle_node_sphere_projection_unit_tb: clean");
    else $display("triangle_node_sphere_projection_unit_tb: errors");
    $finish;
  end

  initial begin
    wait (cycle >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycle);
    $display("triangle_node_sphere_projection_unit_tb: errors");
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/tnsp_pkg.sv
rtl/tnsp_affine.sv
rtl/tnsp_norm.sv
rtl/tnsp_isqrt.sv
rtl/tnsp_div.sv
rtl/triangle_node_sphere_projection_unit.sv
verif/triangle_node_sphere_projection_unit_tb.sv
